[design/gdfw_pkg.sv]
package gdfw_pkg;

	localparam int FIELD_W          = 4;
	localparam int VERTEX_COUNT_DEF = 16;

	localparam logic REQ_ADD_EDGE = 1'b0;
	localparam logic REQ_SEARCH   = 1'b1;

	typedef struct packed {
		logic                 req_type;
		logic [FIELD_W-1:0]   from_vertex;
		logic [FIELD_W-1:0]   to_vertex;
		logic [FIELD_W-1:0]   start_vertex;
	} request_t;

	typedef struct packed {
		logic [FIELD_W-1:0]   visited_vertex;
		logic                 last_of_run;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP,
		ST_CHECK,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;   // empty the stack and place the start vertex
		logic push;
		logic pop;
	} stack_cmd_t;

endpackage

[design/graph_depth_first_walk.sv]
// Depth-first walk over a small directed graph held as an adjacency bit matrix.
// Input channel: request is taken at a clock edge with start high and busy low.
// An add-edge request sets one matrix bit in that cycle; busy stays low and no
// result follows. A search request raises busy until the walk has finished.
// Results: one per visited vertex, in visit order, each shown for one cycle
// with valid high; the last one of a search has last_of_run set. There is no
// back-pressure on results, so the receiver must take each on its strobe.
// Steps of a search: each stack pop goes through pop, then a check against the
// visited set; the neighbour row of every newly visited vertex is then scanned,
// one neighbour per cycle, and stale stack entries are popped and dropped. The
// walk closes with the pop that finds the stack empty, then the final result.
// One search runs at a time.
// A search from an out-of-range vertex gives no result and no busy.
// Each result leaves one visit after it is found, because its last flag is
// only known once the next vertex turns up or the stack runs dry.
// Reset clears the matrix, the visited set and the stack level; the block is
// then idle and ready.
module graph_depth_first_walk import gdfw_pkg::*; #(
	parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  request_t request,
	output logic     busy,
	output logic     valid,
	output result_t  result
);

	localparam int VW = $clog2(VERTEX_COUNT);
	localparam int CW = ((VW > FIELD_W) ? VW : FIELD_W) + 1;

	state_t                  state_q, state_d;
	logic [VERTEX_COUNT-1:0] visited_q;
	logic [VW-1:0]           hold_q;
	logic                    have_q;
	logic [VW-1:0]           n_q;

	stack_cmd_t              stk_cmd;
	logic [VW-1:0]           stk_push_data;
	logic [VW-1:0]           stk_pop_data;
	logic                    stk_empty;
	logic                    adj_wr_en;
	logic                    adj_rd_en;
	logic [VERTEX_COUNT-1:0] adj_row;

	logic                    accept;
	logic                    from_ok, to_ok, start_ok;
	logic                    popped_seen;
	logic                    scan_last;
	logic                    push_n;

	assign accept   = start && (state_q == ST_IDLE);
	assign from_ok  = CW'(request.from_vertex)  < CW'(VERTEX_COUNT);
	assign to_ok    = CW'(request.to_vertex)    < CW'(VERTEX_COUNT);
	assign start_ok = CW'(request.start_vertex) < CW'(VERTEX_COUNT);

	assign popped_seen = visited_q[stk_pop_data];
	assign scan_last   = (n_q == VW'(VERTEX_COUNT - 1));
	assign push_n      = adj_row[n_q] && !visited_q[n_q];
	assign adj_wr_en   = accept && (request.req_type == REQ_ADD_EDGE) && from_ok && to_ok;

	gdfw_stack #(.VERTEX_COUNT(VERTEX_COUNT)) u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (stk_cmd),
		.push_data (stk_push_data),
		.pop_data  (stk_pop_data),
		.empty     (stk_empty)
	);

	gdfw_adj #(.VERTEX_COUNT(VERTEX_COUNT)) u_adj (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (adj_wr_en),
		.wr_from (VW'(request.from_vertex)),
		.wr_to   (VW'(request.to_vertex)),
		.rd_en   (adj_rd_en),
		.rd_addr (stk_pop_data),
		.row     (adj_row)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (request.req_type == REQ_SEARCH) && start_ok) begin
					state_d = ST_POP;
				end
			end
			ST_POP: begin
				state_d = stk_empty ? ST_FINISH : ST_CHECK;
			end
			ST_CHECK: begin
				state_d = popped_seen ? ST_POP : ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_POP;
				end
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		stk_cmd       = '0;
		stk_push_data = n_q;
		adj_rd_en     = 1'b0;
		valid         = 1'b0;
		result.visited_vertex = FIELD_W'(hold_q);
		result.last_of_run    = 1'b0;
		busy          = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy          = 1'b0;
				stk_push_data = VW'(request.start_vertex);
				stk_cmd.load  = accept && (request.req_type == REQ_SEARCH) && start_ok;
			end
			ST_POP: begin
				stk_cmd.pop = !stk_empty;
			end
			ST_CHECK: begin
				adj_rd_en = !popped_seen;
				valid     = !popped_seen && have_q;
			end
			ST_SCAN: begin
				stk_cmd.push = push_n;
			end
			ST_FINISH: begin
				valid              = have_q;
				result.last_of_run = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			visited_q <= '0;
			have_q    <= 1'b0;
			n_q       <= '0;
		end else begin
			state_q <= state_d;
			if (accept && (request.req_type == REQ_SEARCH)) begin
				visited_q <= '0;
				have_q    <= 1'b0;
			end
			if (state_q == ST_CHECK && !popped_seen) begin
				visited_q[stk_pop_data] <= 1'b1;
				have_q                  <= 1'b1;
				n_q                     <= '0;
			end
			if (state_q == ST_SCAN) begin
				n_q <= n_q + VW'(1);
			end
		end
	end

	// newest visited vertex waits here until its successor settles the last flag
	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK && !popped_seen) begin
			hold_q <= stk_pop_data;
		end
	end

endmodule

[design/gdfw_stack.sv]
module gdfw_stack import gdfw_pkg::*; #(
	parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  stack_cmd_t                       cmd,
	input  logic [$clog2(VERTEX_COUNT)-1:0]  push_data,
	output logic [$clog2(VERTEX_COUNT)-1:0]  pop_data,
	output logic                             empty
);

	localparam int VW    = $clog2(VERTEX_COUNT);
	localparam int DEPTH = VERTEX_COUNT * VERTEX_COUNT;
	localparam int AW    = $clog2(DEPTH);
	localparam int LW    = AW + 1;

	logic [VW-1:0] mem [DEPTH];
	logic [LW-1:0] level_q;
	logic [VW-1:0] pop_data_q;
	logic [LW-1:0] top_level;
	logic          full;

	assign top_level = level_q - LW'(1);
	assign full      = (level_q == LW'(DEPTH));
	assign empty     = (level_q == '0);
	assign pop_data  = pop_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (cmd.load) begin
			level_q <= LW'(1);
		end else if (cmd.pop && !empty) begin
			level_q <= top_level;
		end else if (cmd.push && !full) begin
			level_q <= level_q + LW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem[0] <= push_data;
		end else if (cmd.push && !full) begin
			mem[level_q[AW-1:0]] <= push_data;
		end
		if (cmd.pop) begin
			pop_data_q <= mem[top_level[AW-1:0]];
		end
	end

endmodule

[design/gdfw_adj.sv]
module gdfw_adj import gdfw_pkg::*; #(
	parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [$clog2(VERTEX_COUNT)-1:0]  wr_from,
	input  logic [$clog2(VERTEX_COUNT)-1:0]  wr_to,
	input  logic                             rd_en,
	input  logic [$clog2(VERTEX_COUNT)-1:0]  rd_addr,
	output logic [VERTEX_COUNT-1:0]          row
);

	logic [VERTEX_COUNT-1:0] rows_q [VERTEX_COUNT];
	logic [VERTEX_COUNT-1:0] row_q;

	assign row = row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VERTEX_COUNT; i++) begin
				rows_q[i] <= '0;
			end
		end else if (wr_en) begin
			rows_q[wr_from][wr_to] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			row_q <= rows_q[rd_addr];
		end
	end

endmodule
